### hw/rtl/multi_policy_burst_scheduler_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the burst scheduler
// ----------------------------------------------------------------------------
`ifndef MULTI_POLICY_BURST_SCHEDULER_ASSERT_SVH
`define MULTI_POLICY_BURST_SCHEDULER_ASSERT_SVH
// Check that a condition implies a consequence on the same edge
`define MPBS_ASSERT_IMP(label, clk, rst_n, cond, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
else $error("assertion failed");
// Check that a condition implies a consequence on the next edge
`define MPBS_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
else $error("assertion failed");
`endif

### hw/rtl/mpbs_pkg.sv
// ----------------------------------------------------------------------------
// mpbs_pkg
// Shared types and constants of the burst scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package mpbs_pkg;
    localparam int THREADS     = 16;
    localparam int QUEUE_DEPTH = 64;
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = $clog2(THREADS);
    localparam int VW = 40;
    localparam logic [VW-1:0] VR_MAX = {VW{1'b1}};

    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_SJF  = 2'd1;
    localparam logic [1:0] POL_PRIO = 2'd2;
    localparam logic [1:0] POL_VRT  = 2'd3;

    localparam logic [1:0] ST_ENQ   = 2'd0;
    localparam logic [1:0] ST_DISP  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam int EW = 31;

    typedef struct packed {
        logic        req;
        logic [4:0]  thread;
        logic [9:0]  burst;
        logic [15:0] length;
    } cmd_t;
endpackage
`default_nettype wire

### hw/rtl/mpbs_ram.sv
// ----------------------------------------------------------------------------
// mpbs_ram
// Generic single-port write, single read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module mpbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read the array
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### hw/rtl/mpbs_front.sv
// ----------------------------------------------------------------------------
// mpbs_front
// Accepts items and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
`default_nettype none
module mpbs_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire mpbs_pkg::cmd_t in_cmd,
    output logic               q_valid,
    input  wire logic          q_pop,
    output mpbs_pkg::cmd_t     q_cmd
);
    mpbs_pkg::cmd_t slot_reg [2];
    logic       rd_reg, wr_reg;
    logic [1:0] cnt_reg;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = slot_reg[rd_reg];

    // Hold payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            slot_reg[wr_reg] <= in_cmd;
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                wr_reg <= ~wr_reg;
            end
            if (q_pop && q_valid)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, in_valid && in_ready} - {1'b0, q_pop && q_valid};
        end
    end
endmodule
`default_nettype wire

### hw/rtl/mpbs_engine.sv
// ----------------------------------------------------------------------------
// mpbs_engine
// Runs each command: append, scan for the pick, compact, update runtime.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multi_policy_burst_scheduler_assert.svh"
module mpbs_engine (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [1:0]     policy,
    input  wire logic           q_valid,
    output logic                q_pop,
    input  wire mpbs_pkg::cmd_t q_cmd,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [1:0]          out_status,
    output logic [4:0]          out_thread,
    output logic [9:0]          out_burst,
    output logic [15:0]         out_length
);
    localparam int QW = mpbs_pkg::QW;
    localparam int CW = mpbs_pkg::CW;
    localparam int VW = mpbs_pkg::VW;
    localparam int EW = mpbs_pkg::EW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_PICK  = 3'd2;
    localparam logic [2:0] S_MOVE  = 3'd3;
    localparam logic [2:0] S_VMUL  = 3'd4;
    localparam logic [2:0] S_VADD  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]    state_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;      // address issued
    logic          rv_reg;       // read data valid for addr rdi_reg
    logic [QW-1:0] rdi_reg;
    logic [31:0]   seen_reg;
    logic [CW-1:0] distinct_reg;
    logic          have_reg;
    logic          stop_reg;
    logic [QW-1:0] best_reg;
    logic [15:0]   best_len_reg;
    logic [4:0]    best_thr_reg;
    logic [9:0]    best_bur_reg;
    logic [VW-1:0] best_vr_reg;
    logic [VW-1:0] vr_reg [mpbs_pkg::THREADS];
    logic [VW-1:0] add_reg;
    logic          out_valid_reg;
    logic [1:0]    st_reg;
    logic [4:0]    ot_reg;
    logic [9:0]    ob_reg;
    logic [15:0]   ol_reg;

    logic          we;
    logic [QW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;
    logic [4:0]    r_thr;
    logic [9:0]    r_bur;
    logic [15:0]   r_len;
    logic [VW-1:0] r_vr;
    logic          r_ok;
    logic          zero_hit;

    assign r_thr = rdata[EW-1 -: 5];
    assign r_bur = rdata[25:16];
    assign r_len = rdata[15:0];
    assign r_ok  = (r_thr >= 5'd1) && ({1'b0, r_thr} <= 6'(mpbs_pkg::THREADS));
    assign r_vr  = r_ok ? vr_reg[mpbs_pkg::TW'(r_thr - 5'd1)] : mpbs_pkg::VR_MAX;

    mpbs_ram #(.WIDTH(EW), .DEPTH(mpbs_pkg::QUEUE_DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    // Drive RAM ports
    always_comb
    begin
        we    = 1'b0;
        waddr = count_reg[QW-1:0];
        wdata = {q_cmd.thread, q_cmd.burst, q_cmd.length};
        raddr = idx_reg[QW-1:0];
        // Read the head entry while idle, the picked entry once the scan is over
        if (state_reg == S_IDLE)
        begin
            raddr = '0;
        end
        else if (state_reg == S_PICK && !rv_reg)
        begin
            raddr = best_reg;
        end
        if (state_reg == S_IDLE && q_valid && !out_valid_reg && !q_cmd.req
            && count_reg != CW'(mpbs_pkg::QUEUE_DEPTH))
        begin
            we = 1'b1;
        end
        else if (state_reg == S_MOVE && rv_reg)
        begin
            we    = 1'b1;
            waddr = rdi_reg - QW'(1);
            wdata = rdata;
        end
    end

    assign zero_hit = (r_vr == '0);
    assign q_pop    = (state_reg == S_IDLE) && q_valid && !out_valid_reg;

    assign out_valid  = out_valid_reg;
    assign out_status = st_reg;
    assign out_thread = ot_reg;
    assign out_burst  = ob_reg;
    assign out_length = ol_reg;

    // Sequence each command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            rv_reg        <= 1'b0;
            rdi_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < mpbs_pkg::THREADS; k++)
            begin
                vr_reg[k] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        ot_reg <= '0;
                        ob_reg <= '0;
                        ol_reg <= '0;
                        if (!q_cmd.req)
                        begin
                            if (count_reg == CW'(mpbs_pkg::QUEUE_DEPTH))
                            begin
                                st_reg <= mpbs_pkg::ST_FULL;
                            end
                            else
                            begin
                                st_reg    <= mpbs_pkg::ST_ENQ;
                                count_reg <= count_reg + CW'(1);
                            end
                            out_valid_reg <= 1'b1;
                        end
                        else if (count_reg == '0)
                        begin
                            st_reg        <= mpbs_pkg::ST_EMPTY;
                            out_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            idx_reg      <= CW'(1);
                            rdi_reg      <= '0;
                            rv_reg       <= 1'b1;
                            seen_reg     <= '0;
                            distinct_reg <= '0;
                            have_reg     <= 1'b0;
                            stop_reg     <= (policy == mpbs_pkg::POL_FCFS);
                            best_reg     <= '0;
                            state_reg    <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    // Evaluate entry rdi_reg, issue next address
                    if (!stop_reg && !seen_reg[r_thr]
                        && distinct_reg != CW'(mpbs_pkg::THREADS))
                    begin
                        seen_reg[r_thr] <= 1'b1;
                        distinct_reg    <= distinct_reg + CW'(1);
                        have_reg        <= 1'b1;
                        case (policy)
                            mpbs_pkg::POL_SJF:
                            begin
                                if (!have_reg || r_len < best_len_reg)
                                begin
                                    best_reg <= rdi_reg; best_len_reg <= r_len;
                                end
                            end
                            mpbs_pkg::POL_PRIO:
                            begin
                                if (!have_reg || r_thr < best_thr_reg)
                                begin
                                    best_reg <= rdi_reg; best_thr_reg <= r_thr;
                                end
                            end
                            default:
                            begin
                                if (zero_hit)
                                begin
                                    best_reg <= rdi_reg; stop_reg <= 1'b1;
                                end
                                else if (!have_reg || r_vr <= best_vr_reg)
                                begin
                                    best_reg <= rdi_reg; best_vr_reg <= r_vr;
                                end
                            end
                        endcase
                    end
                    if ({1'b0, rdi_reg} + CW'(1) >= count_reg)
                    begin
                        state_reg <= S_PICK;
                        rv_reg    <= 1'b0;
                    end
                    else
                    begin
                        rdi_reg <= rdi_reg + QW'(1);
                        idx_reg <= idx_reg + CW'(1);
                    end
                    if ({1'b0, rdi_reg} + CW'(1) >= count_reg)
                    begin
                        idx_reg <= {1'b0, best_reg};
                    end
                end
                S_PICK:
                begin
                    // Read the picked entry, then start reading the one after it
                    if (rv_reg)
                    begin
                        best_thr_reg <= r_thr;
                        best_bur_reg <= r_bur;
                        best_len_reg <= r_len;
                        idx_reg      <= {1'b0, best_reg} + CW'(2);
                        rdi_reg      <= best_reg + QW'(1);
                        rv_reg       <= ({1'b0, best_reg} + CW'(1) < count_reg);
                        state_reg    <= S_MOVE;
                    end
                    else
                    begin
                        idx_reg <= {1'b0, best_reg} + CW'(1);
                        rv_reg  <= 1'b1;
                    end
                end
                S_MOVE:
                begin
                    // Shift later entries down by one
                    if (rv_reg && {1'b0, rdi_reg} + CW'(1) < count_reg)
                    begin
                        rdi_reg <= rdi_reg + QW'(1);
                        idx_reg <= idx_reg + CW'(1);
                    end
                    else
                    begin
                        rv_reg    <= 1'b0;
                        count_reg <= count_reg - CW'(1);
                        add_reg   <= VW'(32'(best_len_reg)
                                         * (32'd7 + 32'd3 * 32'(best_thr_reg)));
                        state_reg <= S_VMUL;
                    end
                end
                S_VMUL:
                begin
                    state_reg <= S_VADD;
                end
                S_VADD:
                begin
                    if (policy == mpbs_pkg::POL_VRT && best_thr_reg >= 5'd1
                        && {1'b0, best_thr_reg} <= 6'(mpbs_pkg::THREADS))
                    begin
                        if (add_reg >= mpbs_pkg::VR_MAX
                            - vr_reg[mpbs_pkg::TW'(best_thr_reg - 5'd1)])
                        begin
                            vr_reg[mpbs_pkg::TW'(best_thr_reg - 5'd1)] <= mpbs_pkg::VR_MAX;
                        end
                        else
                        begin
                            vr_reg[mpbs_pkg::TW'(best_thr_reg - 5'd1)] <=
                                vr_reg[mpbs_pkg::TW'(best_thr_reg - 5'd1)] + add_reg;
                        end
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    st_reg        <= mpbs_pkg::ST_DISP;
                    ot_reg        <= best_thr_reg;
                    ob_reg        <= best_bur_reg;
                    ol_reg        <= best_len_reg;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `MPBS_ASSERT_IMP(a_pop_idle, clk, rst_n, q_pop, state_reg == S_IDLE)
    `MPBS_ASSERT_IMP(a_cnt_max, clk, rst_n, 1'b1, count_reg <= CW'(mpbs_pkg::QUEUE_DEPTH))
    `MPBS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_status))
endmodule
`default_nettype wire

### hw/rtl/multi_policy_burst_scheduler.sv
// ----------------------------------------------------------------------------
// multi_policy_burst_scheduler
// Ready queue of CPU bursts with four dispatch policies.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per request; tuser holds req_type, tdata holds,
//   from bit 0, thread, burst number and burst length. m_axis returns one
//   result per item: status in tuser, the picked burst in tdata.
//   A two-entry queue sits before the engine, so items are taken while a
//   result waits. An enqueue, empty or full answer is registered by the
//   engine when it pops the item from that queue.
//   A dispatch scans the queued entries through the entry RAM, one per
//   cycle, reads the pick, compacts the tail one entry per cycle, passes
//   the VMUL and VADD states, updating the picked thread's runtime under
//   the VRT policy, and registers the result in the OUT state.
//   The policy register sits at byte address 0 of the APB port.
//   Reset empties the queue, clears all runtimes and sets FCFS. When
//   m_axis_tready is low the result is held and the engine stops before
//   the next item; the input queue then fills and s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none
module multi_policy_burst_scheduler (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [0:0]  s_axis_tuser,  // req_type
    input  wire logic [31:0] s_axis_tdata,  // thread, burst, burst_length
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [1:0]       m_axis_tuser,  // status
    output logic [31:0]      m_axis_tdata,  // picked_thread, picked burst, picked_length
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [1:0]     policy_reg;
    mpbs_pkg::cmd_t in_cmd, q_cmd;
    logic           q_valid, q_pop;
    logic [1:0]     st;
    logic [4:0]     th;
    logic [9:0]     bu;
    logic [15:0]    le;

    assign in_cmd = {s_axis_tuser[0], s_axis_tdata[4:0], s_axis_tdata[14:5],
                     s_axis_tdata[30:15]};

    assign pready = 1'b1;
    assign prdata = paddr ? 32'd0 : {30'd0, policy_reg};

    // Write policy register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= mpbs_pkg::POL_FCFS;
        end
        else if (psel && penable && pwrite && !paddr)
        begin
            policy_reg <= pwdata[1:0];
        end
    end

    mpbs_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_cmd(in_cmd), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
    );

    mpbs_engine u_engine (
        .clk(clk), .rst_n(rst_n), .policy(policy_reg), .q_valid(q_valid), .q_pop(q_pop),
        .q_cmd(q_cmd), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_status(st), .out_thread(th), .out_burst(bu), .out_length(le)
    );

    assign m_axis_tuser = st;
    assign m_axis_tdata = {1'b0, le, bu, th};
endmodule
`default_nettype wire

### tb/multi_policy_burst_scheduler_tb.sv
// ----------------------------------------------------------------------------
// Burst scheduler regression bench
// Drives enqueue and dispatch requests under each dispatch policy, keeps its
// own copy of the ready queue and thread runtimes, and checks every answer.
// ----------------------------------------------------------------------------
`default_nettype none
module multi_policy_burst_scheduler_tb;
    localparam int WATCHDOG = 20000;
    localparam logic [39:0] RT_MAX = 40'hFF_FFFF_FFFF;
    localparam logic REQ_ENQ  = 1'b0;
    localparam logic REQ_DISP = 1'b1;
    localparam logic REG_POLICY = 1'b0;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  thread;
        logic [9:0]  burst;
        logic [15:0] length;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [0:0]  s_axis_tuser;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [1:0]  m_axis_tuser;
    logic [31:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic        paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    multi_policy_burst_scheduler dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tuser(m_axis_tuser), .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Shadow scheduler state
    logic [4:0]  rq_thread [mpbs_pkg::QUEUE_DEPTH];
    logic [9:0]  rq_burst  [mpbs_pkg::QUEUE_DEPTH];
    logic [15:0] rq_length [mpbs_pkg::QUEUE_DEPTH];
    int          rq_count;
    logic [39:0] runtime [mpbs_pkg::THREADS];
    logic [1:0]  cur_policy;

    mpbs_pkg::cmd_t pending_reqs[$];
    answer_t        expected_answers[$];
    int             errors;
    int             idle_cycles;
    bit             sender_calm;
    bit             receiver_calm;
    int             hold_off;
    bit             in_taken;

    function automatic logic [39:0] runtime_of(logic [4:0] t);
        return (t >= 1 && t <= mpbs_pkg::THREADS) ? runtime[t - 1] : RT_MAX;
    endfunction

    // Pick the queue slot to dispatch under the current policy
    function automatic int pick_slot();
        logic [31:0] seen;
        int          distinct;
        int          best;
        logic [39:0] best_rt;
        logic [39:0] v;
        bit          have;
        seen = 0; distinct = 0; best = 0; best_rt = 0; have = 0;
        if (cur_policy == mpbs_pkg::POL_FCFS)
            return 0;
        for (int i = 0; i < rq_count && distinct < mpbs_pkg::THREADS; i++)
        begin
            if (seen[rq_thread[i]])
                continue;
            seen[rq_thread[i]] = 1'b1;
            distinct++;
            if (cur_policy == mpbs_pkg::POL_SJF)
            begin
                if (!have || rq_length[i] < rq_length[best])
                    best = i;
            end
            else if (cur_policy == mpbs_pkg::POL_PRIO)
            begin
                if (!have || rq_thread[i] < rq_thread[best])
                    best = i;
            end
            else
            begin
                v = runtime_of(rq_thread[i]);
                if (v == 0)
                    return i;
                if (!have || v <= best_rt)
                begin
                    best = i;
                    best_rt = v;
                end
            end
            have = 1;
        end
        return best;
    endfunction

    // Advance the shadow state by one request and return its answer
    function automatic answer_t schedule(mpbs_pkg::cmd_t c);
        answer_t     a;
        int          pos;
        logic [63:0] add;
        logic [39:0] cur;
        a = '0;
        if (c.req == REQ_ENQ)
        begin
            if (rq_count >= mpbs_pkg::QUEUE_DEPTH)
            begin
                a.status = mpbs_pkg::ST_FULL;
                return a;
            end
            rq_thread[rq_count] = c.thread;
            rq_burst[rq_count]  = c.burst;
            rq_length[rq_count] = c.length;
            rq_count++;
            a.status = mpbs_pkg::ST_ENQ;
            return a;
        end
        if (rq_count == 0)
        begin
            a.status = mpbs_pkg::ST_EMPTY;
            return a;
        end
        pos = pick_slot();
        if (pos >= rq_count)
            pos = 0;
        a.status = mpbs_pkg::ST_DISP;
        a.thread = rq_thread[pos];
        a.burst  = rq_burst[pos];
        a.length = rq_length[pos];
        if (cur_policy == mpbs_pkg::POL_VRT && a.thread >= 1 && a.thread <= mpbs_pkg::THREADS)
        begin
            add = 64'(a.length) * (64'd7 + 64'd3 * 64'(a.thread));
            cur = runtime[a.thread - 1];
            runtime[a.thread - 1] = (add >= 64'(RT_MAX - cur)) ? RT_MAX : cur + add[39:0];
        end
        for (int i = pos; i + 1 < rq_count; i++)
        begin
            rq_thread[i] = rq_thread[i + 1];
            rq_burst[i]  = rq_burst[i + 1];
            rq_length[i] = rq_length[i + 1];
        end
        rq_count--;
        return a;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    always #10 clk = ~clk;

    // Sample the input handshake at the accepting edge
    always @(posedge clk)
    begin
        in_taken <= s_axis_tvalid && s_axis_tready;
    end

    // Driver: offer pending items, idling at random, hold an offer until taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
                expected_answers.push_back(schedule(pending_reqs.pop_front()));
            if (!s_axis_tvalid || in_taken)
            begin
                if (pending_reqs.size() != 0 && (sender_calm || $urandom_range(99) >= 8))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= pending_reqs[0].req;
                    s_axis_tdata  <= {1'b0, pending_reqs[0].length, pending_reqs[0].burst,
                                      pending_reqs[0].thread};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver readiness, with one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= receiver_calm || $urandom_range(99) >= 8;
        end
    end

    // Monitor: compare each answer with the oldest expectation
    always @(posedge clk)
    begin
        answer_t got;
        answer_t want;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tuser, m_axis_tdata[4:0], m_axis_tdata[14:5],
                       m_axis_tdata[30:15]};
                if (expected_answers.size() == 0)
                    report_mismatch("unexpected answer status", 32'(got.status), 32'd0);
                else
                begin
                    want = expected_answers.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.thread != want.thread)
                        report_mismatch("picked_thread", got.thread, want.thread);
                    if (got.burst != want.burst)
                        report_mismatch("picked burst", got.burst, want.burst);
                    if (got.length != want.length)
                        report_mismatch("picked_length", got.length, want.length);
                end
            end
            if (idle_cycles >= WATCHDOG)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic add_req(logic r, logic [4:0] t, logic [9:0] b, logic [15:0] l);
        mpbs_pkg::cmd_t c;
        c.req = r; c.thread = t; c.burst = b; c.length = l;
        pending_reqs.push_back(c);
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || expected_answers.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        // dispatch latency bound before touching the register
        repeat (2 * mpbs_pkg::QUEUE_DEPTH + 20) @(posedge clk);
    endtask

    task automatic write_policy(logic [1:0] p);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_POLICY; pwdata <= 32'(p);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        cur_policy = p;
    endtask

    // Mostly well-formed traffic: a random mix of enqueues and dispatches
    task automatic random_phase(int n);
        int len_mode;
        for (int i = 0; i < n; i++)
        begin
            len_mode = $urandom_range(9);
            if ($urandom_range(99) < 55)
                add_req(REQ_ENQ,
                        ($urandom_range(19) == 0) ? 5'($urandom_range(31))
                                                  : 5'($urandom_range(mpbs_pkg::THREADS, 1)),
                        10'($urandom),
                        (len_mode == 0) ? 16'hFFFF : (len_mode < 4) ? 16'($urandom)
                                                                    : 16'($urandom_range(40)));
            else
                add_req(REQ_DISP, 5'($urandom), 10'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        clk = 0; rst_n = 0;
        s_axis_tvalid = 0; s_axis_tuser = 0; s_axis_tdata = 0; m_axis_tready = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        errors = 0; idle_cycles = 0; hold_off = 0; in_taken = 0;
        sender_calm = 0; receiver_calm = 0;
        rq_count = 0; cur_policy = mpbs_pkg::POL_FCFS;
        foreach (runtime[i]) runtime[i] = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: empty dispatch, extremes, out-of-range threads
        add_req(REQ_DISP, 5'd0, 10'd0, 16'd0);
        add_req(REQ_ENQ, 5'd16, 10'd1023, 16'hFFFF);
        add_req(REQ_ENQ, 5'd1, 10'd0, 16'd0);
        add_req(REQ_ENQ, 5'd0, 10'd5, 16'd7);
        add_req(REQ_ENQ, 5'd31, 10'd6, 16'd9);
        add_req(REQ_DISP, 5'd31, 10'd1023, 16'hFFFF);
        drain();
        write_policy(mpbs_pkg::POL_VRT);
        add_req(REQ_ENQ, 5'd16, 10'd3, 16'hFFFF);
        add_req(REQ_ENQ, 5'd2, 10'd4, 16'd3);
        for (int i = 0; i < 6; i++)
            add_req(REQ_DISP, 5'd0, 10'd0, 16'd0);
        // Fill past depth: full drops, with the receiver held off
        for (int i = 0; i < mpbs_pkg::QUEUE_DEPTH + 3; i++)
            add_req(REQ_ENQ, 5'($urandom_range(mpbs_pkg::THREADS, 1)), 10'(i), 16'($urandom));
        hold_off = 300;
        drain();

        // Random phases over every policy, extremes included
        for (int ph = 0; ph < 8; ph++)
        begin
            write_policy(2'(ph % 4));
            sender_calm = (ph == 5);
            receiver_calm = (ph == 5);
            random_phase(122);
            drain();
        end
        write_policy(mpbs_pkg::POL_FCFS);
        random_phase(30);
        for (int i = 0; i < mpbs_pkg::QUEUE_DEPTH + 2; i++)
            add_req(REQ_DISP, 5'd0, 10'd0, 16'd0);
        drain();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
